FILE: sv/bbps_pkg.sv
// Shared types and constants for the Brownian bridge path step block.
package bbps_pkg;

    // Default number of path dimensions
    localparam int BBPS_DIMS = 2;

    // Widths of the serial arithmetic units
    localparam int DIV_WIDE   = 64;   // dividend of the scale division
    localparam int DIV_MEAN   = 33;   // magnitude of end minus previous point
    localparam int SQ_IN      = 48;   // radicand of the square root
    localparam int SQ_OUT     = 24;   // root width
    localparam int NOISE_W    = 37;   // noise row after the Q.28 to Q21.16 shift
    localparam int PROD_W     = NOISE_W + SQ_OUT;

    // Request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // Configuration register indexes
    localparam logic [3:0] CFG_N_POINTS = 4'd0;
    localparam logic [3:0] CFG_STEP_DT  = 4'd1;
    localparam logic [3:0] CFG_END_0    = 4'd2;
    localparam logic [3:0] CFG_END_1    = 4'd3;
    localparam logic [3:0] CFG_SIGMA_00 = 4'd4;
    localparam logic [3:0] CFG_SIGMA_01 = 4'd5;
    localparam logic [3:0] CFG_SIGMA_10 = 4'd6;
    localparam logic [3:0] CFG_SIGMA_11 = 4'd7;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_LOAD,
        S_DIV,
        S_SQRT,
        S_MUL,
        S_SUM,
        S_EMIT
    } t_state;

endpackage

FILE: sv/brownian_bridge_path_step.sv
// Top level of the Brownian bridge path step generator.
// A start item is answered with point 0 through the S_EMIT state and the output
// register. A step item runs the setup multiplies, a bit-serial division for the
// variance scale (the two mean divisions run beside it), a square root and a
// serial multiply of the noise by the scale, then a saturating sum. One item is
// worked on at a time; o_stall stays high from acceptance until its result is
// loaded into the output register.
// A step item with no active path gives no result.
module brownian_bridge_path_step import bbps_pkg::*; #(
    parameter int DIMS = BBPS_DIMS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_req_type,
    input  logic signed [31:0] i_start_0,
    input  logic signed [31:0] i_start_1,
    input  logic signed [15:0] i_noise_0,
    input  logic signed [15:0] i_noise_1,
    // Output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_point_index,
    output logic signed [31:0] o_coord_0,
    output logic signed [31:0] o_coord_1,
    output logic               o_last,
    // Configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    t_state r_state, n_state;

    // Configuration registers
    logic [15:0]        r_n_points;
    logic [31:0]        r_step_dt;
    logic signed [31:0] r_end [2];
    logic signed [31:0] r_sig [2][2];

    // Path state
    logic signed [31:0] r_pt [2];
    logic [15:0]        r_step_count;
    logic               r_active;

    // Step working registers
    logic [15:0]        r_idx;
    logic [15:0]        r_k;
    logic signed [15:0] r_w [2];
    logic [47:0]        r_kdt;
    logic signed [47:0] r_pr [2][2];
    logic signed [NOISE_W-1:0] r_nz [2];
    logic               r_neg [2];
    logic signed [31:0] r_new [2];

    // Output register
    logic               r_out_valid;
    logic [15:0]        r_out_idx;
    logic signed [31:0] r_out_c [2];
    logic               r_out_last;

    // Unit handshakes
    logic               div_start, sqrt_start, mul_start;
    logic               div_done, sqrt_done;
    logic [1:0]         mdiv_done, mul_done;
    logic [DIV_WIDE-1:0] div_q;
    logic [DIV_MEAN-1:0] mdiv_q [2];
    logic [DIV_MEAN-1:0] mag [2];
    logic [SQ_OUT-1:0]  root;
    logic signed [PROD_W-1:0] prod [2];

    logic               accept, out_take, out_free;
    logic [15:0]        n_eff, idx_nx, k_nx;
    logic signed [32:0] diff [2];
    logic signed [48:0] acc [2];
    logic signed [33:0] qs [2];
    logic signed [45:0] sum [2];
    logic signed [31:0] sat [2];

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_state != S_IDLE;
    assign accept      = i_valid && !o_stall;
    assign out_take    = r_out_valid && !i_stall;
    assign out_free    = !r_out_valid || !i_stall;

    // Step index and remaining count
    always_comb begin
        n_eff  = (r_n_points < 16'd2) ? 16'd2 : r_n_points;
        idx_nx = r_step_count + 16'd1;
        k_nx   = (idx_nx < n_eff) ? n_eff - idx_nx : 16'd1;
    end

    // Mean differences, noise row sums and the final saturating add
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            diff[j] = 33'(r_end[j]) - 33'(r_pt[j]);
            mag[j]  = diff[j][32] ? DIV_MEAN'(-diff[j]) : DIV_MEAN'(diff[j]);
            acc[j]  = 49'(r_pr[0][j]) + ((DIMS > 1) ? 49'(r_pr[1][j]) : 49'sd0);
            qs[j]   = r_neg[j] ? -$signed({1'b0, mdiv_q[j]}) : $signed({1'b0, mdiv_q[j]});
            sum[j]  = 46'(r_pt[j]) + 46'(qs[j]) + 46'($signed(prod[j][PROD_W-1:16]));
            if (sum[j][45:31] != {15{sum[j][45]}})
                sat[j] = sum[j][45] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            else
                sat[j] = sum[j][31:0];
        end
    end

    // Sequencer next state
    always_comb begin
        n_state    = r_state;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        mul_start  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req_type == REQ_START) n_state = S_EMIT;
                    else if (r_active)           n_state = S_PREP;
                end
            end
            S_PREP: n_state = S_LOAD;
            S_LOAD: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    sqrt_start = 1'b1;
                    n_state    = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sqrt_done) begin
                    mul_start = 1'b1;
                    n_state   = S_MUL;
                end
            end
            S_MUL: if (&mul_done) n_state = S_SUM;
            S_SUM: n_state = S_EMIT;
            S_EMIT: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Configuration writes and path state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_points   <= 16'd2;
            r_step_dt    <= 32'd65536;
            r_end[0]     <= '0;
            r_end[1]     <= '0;
            r_sig[0][0]  <= 32'sd65536;
            r_sig[0][1]  <= '0;
            r_sig[1][0]  <= '0;
            r_sig[1][1]  <= 32'sd65536;
            r_pt[0]      <= '0;
            r_pt[1]      <= '0;
            r_step_count <= '0;
            r_active     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_N_POINTS: r_n_points  <= i_cfg_data[15:0];
                    CFG_STEP_DT:  r_step_dt   <= i_cfg_data;
                    CFG_END_0:    r_end[0]    <= i_cfg_data;
                    CFG_END_1:    r_end[1]    <= i_cfg_data;
                    CFG_SIGMA_00: r_sig[0][0] <= i_cfg_data;
                    CFG_SIGMA_01: r_sig[0][1] <= i_cfg_data;
                    CFG_SIGMA_10: r_sig[1][0] <= i_cfg_data;
                    CFG_SIGMA_11: r_sig[1][1] <= i_cfg_data;
                    default: ;
                endcase
            end
            // Load a new path
            if (accept && i_req_type == REQ_START) begin
                r_pt[0]      <= i_start_0;
                r_pt[1]      <= (DIMS > 1) ? i_start_1 : 32'sd0;
                r_step_count <= '0;
                r_active     <= 1'b1;
            end
            // Commit the new point
            if (r_state == S_SUM) begin
                r_pt[0]      <= sat[0];
                r_pt[1]      <= (DIMS > 1) ? sat[1] : 32'sd0;
                r_step_count <= r_idx;
                if (r_k == 16'd1) r_active <= 1'b0;
            end
            // Output register valid
            if (r_state == S_EMIT && out_free) r_out_valid <= 1'b1;
            else if (out_take)                 r_out_valid <= 1'b0;
        end
    end

    // Step working registers and output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_w[0] <= i_noise_0;
            r_w[1] <= i_noise_1;
            r_k    <= (i_req_type == REQ_START) ? 16'd0 : k_nx;
            r_idx  <= (i_req_type == REQ_START) ? 16'd0 : idx_nx;
        end
        if (r_state == S_PREP) begin
            r_kdt <= 48'(r_k - 16'd1) * 48'(r_step_dt);
            for (int r = 0; r < 2; r++)
                for (int j = 0; j < 2; j++)
                    r_pr[r][j] <= 48'(r_w[r]) * 48'(r_sig[r][j]);
        end
        if (r_state == S_LOAD) begin
            for (int j = 0; j < 2; j++) begin
                r_nz[j]  <= acc[j][48:12];
                r_neg[j] <= diff[j][32];
            end
        end
        if (r_state == S_EMIT && out_free) begin
            r_out_idx  <= r_idx;
            r_out_c[0] <= r_pt[0];
            r_out_c[1] <= r_pt[1];
            r_out_last <= r_k == 16'd1;
        end
        r_new[0] <= sat[0];
        r_new[1] <= sat[1];
    end

    // Scale division: (k-1)*dt*2^16 / k
    bbps_div #(.W(DIV_WIDE)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_kdt, 16'h0000}),
        .i_divisor  (r_k),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Mean divisions and noise scaling, one lane per coordinate
    for (genvar j = 0; j < 2; j++) begin : g_lane
        bbps_div #(.W(DIV_MEAN)) u_mdiv (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (div_start),
            .i_dividend (mag[j]),
            .i_divisor  (r_k),
            .o_done     (mdiv_done[j]),
            .o_quotient (mdiv_q[j])
        );
        bbps_mul u_mul (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (mul_start),
            .i_a     (r_nz[j]),
            .i_b     (root),
            .o_done  (mul_done[j]),
            .o_p     (prod[j])
        );
    end

    bbps_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (div_q[SQ_IN-1:0]),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    assign o_valid       = r_out_valid;
    assign o_point_index = r_out_idx;
    assign o_coord_0     = r_out_c[0];
    assign o_coord_1     = r_out_c[1];
    assign o_last        = r_out_last;

    // The mean divisions finish before the scale division
    a_mdiv_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> $past(mdiv_done[0], 31) && $past(mdiv_done[1], 31))
        else $error("mean division still running");

    // A last point ends the path
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) && r_out_last |-> !r_active)
        else $error("path still active after last point");

    // The committed first coordinate is the saturated sum
    a_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state == S_SUM) |-> r_pt[0] == r_new[0])
        else $error("point commit mismatch");

    // Input is stalled while a step is in progress
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_stall)
        else $error("input not stalled while busy");
endmodule

FILE: sv/bbps_div.sv
// Bit-serial restoring divider by a 16-bit unsigned divisor.
module bbps_div import bbps_pkg::*; #(
    parameter int W = DIV_WIDE
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [W-1:0]  i_dividend,
    input  logic [15:0]   i_divisor,
    output logic          o_done,
    output logic [W-1:0]  o_quotient
);
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [15:0]   r_rem;
    logic [15:0]   r_div;
    logic [W-1:0]  r_q;

    logic [16:0]   rem_sh;
    logic [16:0]   rem_nx;
    logic          ge;
    logic          last;

    // Trial subtract of one quotient bit
    always_comb begin
        rem_sh = {r_rem, r_q[W-1]};
        ge     = rem_sh >= {1'b0, r_div};
        rem_nx = ge ? rem_sh - {1'b0, r_div} : rem_sh;
        last   = r_cnt == CW'(W - 1);
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) r_busy <= 1'b0;
            end
        end
    end

    // Shift dividend out and quotient in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[W-2:0], ge};
            r_rem <= rem_nx[15:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

FILE: sv/bbps_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module bbps_sqrt import bbps_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_IN-1:0]  i_radicand,
    output logic              o_done,
    output logic [SQ_OUT-1:0] o_root
);
    localparam int CW = $clog2(SQ_OUT);
    localparam int RW = SQ_OUT + 2;

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [SQ_IN-1:0]  r_rad;
    logic [RW-1:0]     r_rem;
    logic [SQ_OUT-1:0] r_root;

    logic [RW+1:0]     rem_sh;
    logic [RW+1:0]     trial;
    logic [RW+1:0]     rem_nx;
    logic              ge;
    logic              last;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
        rem_sh = {r_rem, r_rad[SQ_IN-1 -: 2]};
        trial  = {2'b00, r_root, 2'b01};
        ge     = rem_sh >= trial;
        rem_nx = ge ? rem_sh - trial : rem_sh;
        last   = r_cnt == CW'(SQ_OUT - 1);
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) r_busy <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[SQ_IN-3:0], 2'b00};
            r_rem  <= rem_nx[RW-1:0];
            r_root <= {r_root[SQ_OUT-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

FILE: sv/bbps_mul.sv
// Bit-serial shift-add multiplier: signed noise times unsigned scale, MSB first.
module bbps_mul import bbps_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [NOISE_W-1:0] i_a,
    input  logic        [SQ_OUT-1:0]  i_b,
    output logic                     o_done,
    output logic signed [PROD_W-1:0] o_p
);
    localparam int CW = $clog2(SQ_OUT);

    logic                      r_busy;
    logic                      r_done;
    logic [CW-1:0]             r_cnt;
    logic signed [NOISE_W-1:0] r_a;
    logic [SQ_OUT-1:0]         r_b;
    logic signed [PROD_W-1:0]  r_p;
    logic signed [PROD_W-1:0]  p_nx;
    logic                      last;

    // Double and add the next multiplier bit
    always_comb begin
        p_nx = (r_p <<< 1) + (r_b[SQ_OUT-1] ? PROD_W'(r_a) : '0);
        last = r_cnt == CW'(SQ_OUT - 1);
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) r_busy <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            r_b <= {r_b[SQ_OUT-2:0], 1'b0};
            r_p <= p_nx;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule
